// ===== rtl/bdq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and constants for the bounded deque cell row.
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int DEPTH = 16;
  localparam int IDXW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int PW    = (CW > 5) ? CW : 5;

  // func codes
  localparam logic [2:0] F_INS_FRONT = 3'd0;
  localparam logic [2:0] F_INS_BACK  = 3'd1;
  localparam logic [2:0] F_INS_POS   = 3'd2;
  localparam logic [2:0] F_REM_FRONT = 3'd3;
  localparam logic [2:0] F_REM_BACK  = 3'd4;
  localparam logic [2:0] F_READ_ALL  = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] value;
    logic [4:0]         position;
  } req_t;

  typedef struct packed {
    logic signed [31:0] item;
    logic [1:0]         status;
    logic               last;
  } rsp_t;

  // row-wide command broadcast to every cell
  typedef struct packed {
    logic              insert;
    logic              shift_left;
    logic              rotate;
    logic [IDXW-1:0]   pos;
    logic [IDXW-1:0]   last_idx;
    logic signed [31:0] value;
  } ctl_t;

endpackage

// ===== rtl/bdq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_cell
// One storage cell of the row; loads from a neighbor, the insert value or
// the head of the row, as the broadcast command and its own index decide.
// ----------------------------------------------------------------------------
module bdq_cell (
  input  logic                      clk,
  input  logic [bdq_pkg::IDXW-1:0]  idx,
  input  bdq_pkg::ctl_t             ctl,
  input  logic signed [31:0]        left_data,
  input  logic signed [31:0]        right_data,
  input  logic signed [31:0]        head_data,
  output logic signed [31:0]        data
);

  logic signed [31:0] data_next;

  always_comb begin
    data_next = data;
    if (ctl.insert) begin
      if (idx > ctl.pos) begin
        data_next = left_data;
      end else if (idx == ctl.pos) begin
        data_next = ctl.value;
      end
    end else if (ctl.shift_left) begin
      data_next = right_data;
    end else if (ctl.rotate) begin
      // circular shift over the occupied cells only
      if (idx == ctl.last_idx) begin
        data_next = head_data;
      end else if (idx < ctl.last_idx) begin
        data_next = right_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

// ===== rtl/bounded_deque_with_positional_insert_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_with_positional_insert_unit
// Bounded deque of signed 32-bit values held in a shifting row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req) carries one operation per transfer:
//   insert front, insert back, insert at position, remove front, remove back
//   or read all. rsp channel (rsp_valid/rsp_ready/rsp) returns the results.
//   Inserts and removes give one result, registered: it appears on rsp the
//   cycle after the request transfer, and a new request is taken in that
//   same cycle if the receiver takes the result, so one item per cycle.
//   Read all gives count results, one per cycle while the receiver takes them, cell 0 first; the row
//   rotates by one cell per result and is back in order after the last one.
//   req_ready stays low during the read-out, so a read-all occupies the
//   block until its last result is loaded (a single result when empty).
//   When the receiver stalls, the result register holds and req_ready drops;
//   the row rotation also pauses, so nothing is lost or repeated.
//   Reset clears the count and the control state; cell contents are not
//   cleared since only cells below count are ever read.
//   func codes 6 and 7 are taken and dropped without a result.
// ----------------------------------------------------------------------------
module bounded_deque_with_positional_insert_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  bdq_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output bdq_pkg::rsp_t  rsp
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic                      state, state_next;
  logic [bdq_pkg::CW-1:0]    count, count_next;
  logic [bdq_pkg::CW-1:0]    rd_left, rd_left_next;
  logic [bdq_pkg::CW-1:0]    cnt_m1;
  logic [bdq_pkg::PW-1:0]    pos_ext, cnt_ext, pos_clamp;
  logic                      out_free, take, load_out, full, empty;
  bdq_pkg::rsp_t             out_next;
  bdq_pkg::ctl_t             ctl;
  logic signed [31:0]        cell_q [bdq_pkg::DEPTH];

  // Row of cells: cell 0 is the front of the sequence.
  for (genvar i = 0; i < bdq_pkg::DEPTH; i++) begin : g_cell
    logic signed [31:0] left_d, right_d;
    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_q[i-1];
    end
    if (i == bdq_pkg::DEPTH - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_q[i+1];
    end
    bdq_cell u_cell (
      .clk        (clk),
      .idx        (bdq_pkg::IDXW'(i)),
      .ctl        (ctl),
      .left_data  (left_d),
      .right_data (right_d),
      .head_data  (cell_q[0]),
      .data       (cell_q[i])
    );
  end

  assign out_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE) && out_free;
  assign take      = req_valid && req_ready;

  assign full   = (count == bdq_pkg::CW'(bdq_pkg::DEPTH));
  assign empty  = (count == '0);
  assign cnt_m1 = count - bdq_pkg::CW'(1);

  // position beyond count lands at the back
  assign pos_ext   = bdq_pkg::PW'(req.position);
  assign cnt_ext   = bdq_pkg::PW'(count);
  assign pos_clamp = (pos_ext > cnt_ext) ? cnt_ext : pos_ext;

  always_comb begin
    ctl            = '0;
    ctl.value      = req.value;
    ctl.last_idx   = cnt_m1[bdq_pkg::IDXW-1:0];
    count_next     = count;
    state_next     = state;
    rd_left_next   = rd_left;
    load_out       = 1'b0;
    out_next       = '0;
    if (take) begin
      unique case (req.func)
        bdq_pkg::F_INS_FRONT, bdq_pkg::F_INS_BACK, bdq_pkg::F_INS_POS: begin
          load_out      = 1'b1;
          out_next.last = 1'b1;
          if (full) begin
            out_next.status = bdq_pkg::ST_FULL;
          end else begin
            out_next.status = bdq_pkg::ST_OK;
            ctl.insert      = 1'b1;
            count_next      = count + bdq_pkg::CW'(1);
            if (req.func == bdq_pkg::F_INS_FRONT) begin
              ctl.pos = '0;
            end else if (req.func == bdq_pkg::F_INS_BACK) begin
              ctl.pos = count[bdq_pkg::IDXW-1:0];
            end else begin
              ctl.pos = pos_clamp[bdq_pkg::IDXW-1:0];
            end
          end
        end
        bdq_pkg::F_REM_FRONT: begin
          load_out      = 1'b1;
          out_next.last = 1'b1;
          if (empty) begin
            out_next.status = bdq_pkg::ST_EMPTY;
          end else begin
            out_next.item   = cell_q[0];
            out_next.status = bdq_pkg::ST_OK;
            ctl.shift_left  = 1'b1;
            count_next      = cnt_m1;
          end
        end
        bdq_pkg::F_REM_BACK: begin
          load_out      = 1'b1;
          out_next.last = 1'b1;
          if (empty) begin
            out_next.status = bdq_pkg::ST_EMPTY;
          end else begin
            out_next.item   = cell_q[cnt_m1[bdq_pkg::IDXW-1:0]];
            out_next.status = bdq_pkg::ST_OK;
            count_next      = cnt_m1;
          end
        end
        bdq_pkg::F_READ_ALL: begin
          load_out = 1'b1;
          if (empty) begin
            out_next.status = bdq_pkg::ST_EMPTY;
            out_next.last   = 1'b1;
          end else begin
            // first result now, the rest from the read state
            out_next.item   = cell_q[0];
            out_next.status = bdq_pkg::ST_OK;
            out_next.last   = (count == bdq_pkg::CW'(1));
            ctl.rotate      = 1'b1;
            if (count != bdq_pkg::CW'(1)) begin
              state_next   = S_READ;
              rd_left_next = cnt_m1;
            end
          end
        end
        default: begin
          // unused codes: dropped, no result
        end
      endcase
    end else if (state == S_READ && out_free) begin
      load_out        = 1'b1;
      out_next.item   = cell_q[0];
      out_next.status = bdq_pkg::ST_OK;
      out_next.last   = (rd_left == bdq_pkg::CW'(1));
      ctl.rotate      = 1'b1;
      rd_left_next    = rd_left - bdq_pkg::CW'(1);
      if (rd_left == bdq_pkg::CW'(1)) begin
        state_next = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rd_left   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      rd_left <= rd_left_next;
      if (load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (load_out) begin
      rsp <= out_next;
    end
  end

endmodule
